FILE: sv/jqkr_pkg.sv
// shared types and constants for the job queue with keyed removal
package jqkr_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int CMD_W    = 2;
  localparam int JOB_W    = 16;
  localparam int PROC_W   = 22;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  localparam int IN_BITS  = CMD_W + JOB_W + PROC_W + PROC_W;
  localparam int OUT_BITS = STATUS_W + JOB_W + PROC_W + POS_W + COUNT_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_BY_JOB  = 2'd2,
    CMD_BY_PROC = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [PROC_W-1:0] proc_id;
    logic [JOB_W-1:0]  job_id;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DONE
  } state_t;

endpackage

FILE: sv/job_queue_with_keyed_removal.sv
// job queue with keyed removal: entry memory, scan and close-up sequencer
//
// Slave stream (s_*) takes one command item, master stream (m_*) gives
// exactly one result item per command, in order.
// Commands: enqueue at tail, dequeue head, remove the first entry from the
// head whose job id or process id equals the search key. Entries behind a
// removed one move up one rank, so position is always rank from the head.
// The entries sit in a single-port-read memory of QUEUE_DEPTH words with a
// registered read; the sequencer handles one command at a time.
// Sequence: an enqueue, also a refused one, goes straight to the result;
// a removal at rank r scans from the head (one read and one compare per
// rank), then closes up behind rank r (one read and one write back per
// moved entry); a miss scans all held entries before it reports.
// The next command is taken as soon as the sequencer is idle, even while
// the previous result still waits in the output register; a stalled
// receiver only holds the sequencer once a second result is ready.
// Reset empties the queue at once (count to zero); the memory is not
// cleared since only ranks below the count are ever used.
module job_queue_with_keyed_removal
  import jqkr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // command[1:0], job_id[17:2], proc_id[39:18], search_key[61:40]
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // status[1:0], out_job_id[17:2], out_proc_id[39:18], position[43:40],
  // entry_count[48:44]
  output logic [OUT_W-1:0] m_tdata
);

  // input unpacking
  cmd_t              in_cmd;
  logic [JOB_W-1:0]  in_job;
  logic [PROC_W-1:0] in_proc;
  logic [PROC_W-1:0] in_key;

  assign in_cmd  = cmd_t'(s_tdata[CMD_W-1:0]);
  assign in_job  = s_tdata[CMD_W +: JOB_W];
  assign in_proc = s_tdata[CMD_W+JOB_W +: PROC_W];
  assign in_key  = s_tdata[CMD_W+JOB_W+PROC_W +: PROC_W];

  state_t            state, state_next;
  cmd_t              cmd;
  logic [PROC_W-1:0] key;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  rank;
  logic [CNT_W-1:0]  rank_inc;

  status_t           res_status;
  entry_t            res_entry;
  logic [POS_W-1:0]  res_pos;

  entry_t            mem [QUEUE_DEPTH];
  entry_t            rd_data;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;

  logic              in_fire;
  logic              out_load;
  logic              full;
  logic              match;

  assign in_fire  = s_tvalid && s_tready;
  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign rank_inc = rank + CNT_W'(1);

  // dequeue takes whatever sits at rank 0
  always_comb begin
    case (cmd)
      CMD_DEQUEUE: match = 1'b1;
      CMD_BY_JOB:  match = ({{(PROC_W-JOB_W){1'b0}}, rd_data.job_id} == key);
      CMD_BY_PROC: match = (rd_data.proc_id == key);
      default:     match = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (in_cmd == CMD_ENQUEUE) ? ST_DONE : ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        state_next = (rank == count) ? ST_DONE : ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        state_next = match ? ST_SHIFT_RD : ST_SCAN_RD;
      end
      ST_SHIFT_RD: begin
        state_next = (rank_inc >= count) ? ST_DONE : ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        state_next = ST_SHIFT_RD;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready  = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = count[IDX_W-1:0];
    mem_wdata = '{proc_id: in_proc, job_id: in_job};
    mem_raddr = rank[IDX_W-1:0];
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        mem_we   = s_tvalid && (in_cmd == CMD_ENQUEUE) && !full;
      end
      ST_SHIFT_RD: begin
        mem_raddr = rank_inc[IDX_W-1:0];
      end
      ST_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = rank[IDX_W-1:0];
        mem_wdata = rd_data;
      end
      ST_DONE: begin
        out_load = !m_tvalid || m_tready;
      end
      default: ;
    endcase
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire && (in_cmd == CMD_ENQUEUE) && !full) begin
        count <= count + CNT_W'(1);
      end else if ((state == ST_SHIFT_RD) && (rank_inc >= count)) begin
        count <= count - CNT_W'(1);
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // command and result registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          cmd       <= in_cmd;
          key       <= in_key;
          rank      <= '0;
          res_entry <= '0;
          if (in_cmd == CMD_ENQUEUE) begin
            res_status <= full ? STAT_FULL : STAT_OK;
            res_pos    <= full ? '0 : POS_W'(count);
          end else begin
            res_status <= STAT_OK;
            res_pos    <= '0;
          end
        end
      end
      ST_SCAN_RD: begin
        if (rank == count) begin
          res_status <= STAT_MISS;
        end
      end
      ST_SCAN_CMP: begin
        if (match) begin
          res_entry <= rd_data;
          res_pos   <= POS_W'(rank);
        end else begin
          rank <= rank_inc;
        end
      end
      ST_SHIFT_WR: begin
        rank <= rank_inc;
      end
      default: ;
    endcase
    if (out_load) begin
      m_tdata <= {{(OUT_W-OUT_BITS){1'b0}}, COUNT_W'(count), res_pos,
                  res_entry.proc_id, res_entry.job_id, res_status};
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      (({1'b0, count} == {1'b0, $past(count)} + 1'b1) ||
       ({1'b0, count} + 1'b1 == {1'b0, $past(count)})))
    else $error("entry count moved by more than one");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT_WR) |-> (rank_inc < count))
    else $error("close-up write beyond held entries");

  a_result_issued: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid)
    else $error("finished command produced no result");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready)
    else $error("second command taken while one is in work");
`endif

endmodule

FILE: tb/job_queue_with_keyed_removal_test.sv
// testbench for the job queue with keyed removal: directed table, random commands, scoreboard
`timescale 1ns / 100ps

module job_queue_with_keyed_removal_test;
  import jqkr_pkg::*;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [POS_W-1:0]    pos;
    logic [PROC_W-1:0]   proc_id;
    logic [JOB_W-1:0]    job_id;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef struct {
    cmd_t              cmd;
    logic [JOB_W-1:0]  job_id;
    logic [PROC_W-1:0] proc_id;
    logic [PROC_W-1:0] key;
    bit                typed;
    result_t           want;
  } step_t;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  entry_t  held_entries[$];
  result_t expected_results[$];
  step_t   script[$];
  int errors = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_cycles = 0;

  job_queue_with_keyed_removal u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("job_queue_with_keyed_removal_test failed");
    $finish;
  end

  // queue mirror: applies one command and returns the result it must give
  function automatic result_t apply_command(cmd_t c, logic [JOB_W-1:0] j,
                                            logic [PROC_W-1:0] p, logic [PROC_W-1:0] k);
    result_t r;
    entry_t  e;
    int      hit;
    r   = '0;
    hit = -1;
    case (c)
      CMD_ENQUEUE: begin
        if (held_entries.size() >= QUEUE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          r.pos = POS_W'(held_entries.size());
          e.job_id  = j;
          e.proc_id = p;
          held_entries.push_back(e);
        end
      end
      CMD_DEQUEUE: begin
        if (held_entries.size() == 0) r.status = STAT_MISS;
        else hit = 0;
      end
      default: begin
        // job id compare is zero-extended, so keys above 16 bits never match
        for (int i = 0; i < held_entries.size(); i++) begin
          if (hit < 0) begin
            if (c == CMD_BY_JOB && {6'b0, held_entries[i].job_id} == k) hit = i;
            if (c == CMD_BY_PROC && held_entries[i].proc_id == k) hit = i;
          end
        end
        if (hit < 0) r.status = STAT_MISS;
      end
    endcase
    if (hit >= 0) begin
      r.status  = STAT_OK;
      r.job_id  = held_entries[hit].job_id;
      r.proc_id = held_entries[hit].proc_id;
      r.pos     = POS_W'(hit);
      held_entries.delete(hit);
    end
    r.count = COUNT_W'(held_entries.size());
    return r;
  endfunction

  function automatic void add_step(cmd_t c, logic [JOB_W-1:0] j, logic [PROC_W-1:0] p,
                                   logic [PROC_W-1:0] k, bit typed = 1'b0,
                                   logic [STATUS_W-1:0] st = '0, logic [JOB_W-1:0] oj = '0,
                                   logic [PROC_W-1:0] op = '0, logic [POS_W-1:0] pos = '0,
                                   logic [COUNT_W-1:0] cnt = '0);
    step_t s;
    s.cmd          = c;
    s.job_id       = j;
    s.proc_id      = p;
    s.key          = k;
    s.typed        = typed;
    s.want.status  = st;
    s.want.job_id  = oj;
    s.want.proc_id = op;
    s.want.pos     = pos;
    s.want.count   = cnt;
    script.push_back(s);
  endfunction

  task automatic offer_command(cmd_t c, logic [JOB_W-1:0] j, logic [PROC_W-1:0] p,
                               logic [PROC_W-1:0] k);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W - IN_BITS){1'b0}}, k, p, j, c};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
  endtask

  // receiver: random stalls, or a long hold when one is requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  // scoreboard
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[OUT_BITS-1:0];
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, got %h", $time, got);
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status)
          note_mismatch("status", 32'(want.status), 32'(got.status));
        if (got.job_id != want.job_id)
          note_mismatch("out_job_id", 32'(want.job_id), 32'(got.job_id));
        if (got.proc_id != want.proc_id)
          note_mismatch("out_proc_id", 32'(want.proc_id), 32'(got.proc_id));
        if (got.pos != want.pos)
          note_mismatch("position", 32'(want.pos), 32'(got.pos));
        if (got.count != want.count)
          note_mismatch("entry_count", 32'(want.count), 32'(got.count));
      end
    end
  end

  initial begin : stimulus
    step_t             row;
    result_t           predicted;
    entry_t            e;
    cmd_t              c;
    logic [JOB_W-1:0]  j;
    logic [PROC_W-1:0] p;
    logic [PROC_W-1:0] k;
    int                pick;
    int                wait_cycles;
    int                enq_bias[7] = '{60, 45, 80, 25, 50, 90, 35};

    // empty queue, extremes, zero-extension of the job id key, full refusal
    add_step(CMD_DEQUEUE, 16'hFFFF, 22'h3FFFFF, 22'h3FFFFF, 1, STAT_MISS);
    add_step(CMD_BY_PROC, 16'h0, 22'h0, 22'h3FFFFF, 1, STAT_MISS);
    add_step(CMD_ENQUEUE, 16'hFFFF, 22'h3FFFFF, 22'h0, 1, STAT_OK, 0, 0, 0, 1);
    add_step(CMD_ENQUEUE, 16'h0, 22'h0, 22'h3FFFFF, 1, STAT_OK, 0, 0, 1, 2);
    add_step(CMD_BY_JOB, 16'h0, 22'h0, 22'h010000, 1, STAT_MISS, 0, 0, 0, 2);
    add_step(CMD_BY_JOB, 16'h0, 22'h0, 22'h3FFFFF, 1, STAT_MISS, 0, 0, 0, 2);
    add_step(CMD_BY_PROC, 16'h0, 22'h0, 22'h3FFFFF, 1, STAT_OK, 16'hFFFF, 22'h3FFFFF, 0, 1);
    add_step(CMD_DEQUEUE, 16'h0, 22'h0, 22'h0, 1, STAT_OK, 0, 0, 0, 0);
    for (int i = 0; i < QUEUE_DEPTH; i++)
      add_step(CMD_ENQUEUE, JOB_W'(i * 16'h1111), PROC_W'(i * 22'h040001), 22'h0, 1,
               STAT_OK, 0, 0, POS_W'(i), COUNT_W'(i + 1));
    add_step(CMD_ENQUEUE, 16'h1234, 22'h1234, 22'h0, 1, STAT_FULL, 0, 0, 0, 16);
    add_step(CMD_BY_JOB, 16'h0, 22'h0, 22'h00FFFF);
    add_step(CMD_BY_PROC, 16'h0, 22'h0, 22'h000000);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    sender_idle_pct    = 21;
    receiver_stall_pct = 21;
    foreach (script[i]) begin
      row = script[i];
      offer_command(row.cmd, row.job_id, row.proc_id, row.key);
      predicted = apply_command(row.cmd, row.job_id, row.proc_id, row.key);
      expected_results.push_back(row.typed ? row.want : predicted);
    end

    for (int seg = 0; seg < 7; seg++) begin
      case (seg % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 72; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 72; end
        default: begin sender_idle_pct = 21; receiver_stall_pct = 21; end
      endcase
      // long receiver hold so the block backs up into its input
      if (seg == 2 || seg == 5) hold_cycles = 400;
      for (int n = 0; n < 250; n++) begin
        if ($urandom_range(0, 99) < enq_bias[seg]) c = CMD_ENQUEUE;
        else c = cmd_t'($urandom_range(1, 3));
        j = $urandom_range(0, 1) ? JOB_W'($urandom_range(0, 7)) : JOB_W'($urandom());
        p = $urandom_range(0, 1) ? PROC_W'($urandom_range(0, 7)) : PROC_W'($urandom());
        pick = $urandom_range(0, 9);
        if (held_entries.size() > 0 && pick < 8) begin
          e = held_entries[$urandom_range(0, held_entries.size() - 1)];
          if (pick == 7) k = {6'($urandom_range(1, 63)), e.job_id}; // upper bits break it
          else if (c == CMD_BY_JOB) k = {6'b0, e.job_id};
          else k = e.proc_id;
        end else if (pick == 9) begin
          k = PROC_W'($urandom());
        end else begin
          k = PROC_W'($urandom_range(0, 7));
        end
        offer_command(c, j, p, k);
        expected_results.push_back(apply_command(c, j, p, k));
      end
    end
    s_tvalid <= 1'b0;

    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < 100_000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("job_queue_with_keyed_removal_test passed");
    end else begin
      $display("job_queue_with_keyed_removal_test failed");
    end
    $finish;
  end

endmodule
